### src/gsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared widths, codes, control structs and per-gas curve constants for the
// gas sensor concentration block.
// ----------------------------------------------------------------------------
package gsc_pkg;

   localparam int ADC_W   = 12;
   localparam int GAS_W   = 3;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 3;
   localparam int CONC_W  = 22;
   localparam int RATIO_W = 18;
   localparam int MIN_W   = 8;
   localparam int MS_W    = 32;
   localparam int WIN_W   = 24;
   localparam int DIV_W   = 31;
   localparam int QUO_W   = 22;
   localparam int STEP_W  = 5;
   localparam int Q16_W   = 16;
   localparam int PROD_W  = 32;
   localparam int DIFF_W  = 33;
   localparam int BASE_W  = 32;
   localparam int NUM_W   = 36;

   localparam logic [MIN_W-1:0]          MINUTES_RESET = 8'd3;
   localparam logic [15:0]               MS_PER_MINUTE = 16'd60000;
   localparam logic signed [15:0]        Q16_SCALE     = 16'sd15625;  // 1e6 / 64
   localparam logic [4:0]                CONC_SCALE    = 5'd25;       // 100 / 4
   localparam logic signed [RATIO_W-1:0] RATIO_ONE     = 18'sd65536;
   localparam logic [CONC_W-1:0]         CONC_MAX      = 22'd2500000;
   localparam logic [STEP_W-1:0]         RDIV_STEPS    = 5'd16;
   localparam logic [STEP_W-1:0]         CDIV_STEPS    = 5'd22;

   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POLL   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MEAS   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_IGNORE = 2'd3;

   localparam logic [STAT_W-1:0] STAT_TICK     = 3'd0;
   localparam logic [STAT_W-1:0] STAT_WARMING  = 3'd1;
   localparam logic [STAT_W-1:0] STAT_BASELINE = 3'd2;
   localparam logic [STAT_W-1:0] STAT_MEASURED = 3'd3;
   localparam logic [STAT_W-1:0] STAT_BAD_GAS  = 3'd4;

   localparam logic [GAS_W-1:0] GAS_CO      = 3'd0;
   localparam logic [GAS_W-1:0] GAS_CH4     = 3'd1;
   localparam logic [GAS_W-1:0] GAS_ETHANOL = 3'd2;
   localparam logic [GAS_W-1:0] GAS_H2      = 3'd3;
   localparam logic [GAS_W-1:0] GAS_NH3     = 3'd4;
   localparam logic [GAS_W-1:0] GAS_NO2     = 3'd5;
   localparam logic [GAS_W-1:0] NUM_GASES   = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RDIV,
      ST_MUL,
      ST_NUM,
      ST_SCALE,
      ST_CHK,
      ST_CDIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic tick;
      logic poll;
   } warm_cmd_type;

   typedef struct packed {
      logic              capture;
      logic [ADC_W-1:0]  baseline;
   } warm_stat_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  rem_init;
      logic [QUO_W-1:0]  low;
      logic [STEP_W-1:0] steps;
      logic [DIV_W-1:0]  divisor;
   } div_cmd_type;

   // threshold scaled by 1024
   function automatic logic [DIV_W-1:0] curve_thr(input logic [GAS_W-1:0] gas);
      logic [DIV_W-1:0] v;
      unique case (gas)
         GAS_CO:      v = 31'd435200000;
         GAS_CH4:     v = 31'd804864000;
         GAS_ETHANOL: v = 31'd313344000;
         GAS_H2:      v = 31'd285696000;
         GAS_NH3:     v = 31'd819200000;
         GAS_NO2:     v = 31'd1126400000;
         default:     v = '0;
      endcase
      return v;
   endfunction

   // offset scaled by 1024, rising curve only
   function automatic logic [DIV_W-1:0] curve_off(input logic [GAS_W-1:0] gas);
      logic [DIV_W-1:0] v;
      unique case (gas)
         GAS_NO2: v = 31'd46080000;
         default: v = '0;
      endcase
      return v;
   endfunction

   // slope scaled by 256
   function automatic logic [DIV_W-1:0] curve_div(input logic [GAS_W-1:0] gas);
      logic [DIV_W-1:0] v;
      unique case (gas)
         GAS_CO:      v = 31'd103680;
         GAS_CH4:     v = 31'd5888;
         GAS_ETHANOL: v = 31'd145920;
         GAS_H2:      v = 31'd66560;
         GAS_NH3:     v = 31'd384000;
         GAS_NO2:     v = 31'd1569280000;
         default:     v = 31'd1;
      endcase
      return v;
   endfunction

   function automatic logic [CONC_W-1:0] curve_floor(input logic [GAS_W-1:0] gas);
      logic [CONC_W-1:0] v;
      unique case (gas)
         GAS_CO:      v = 22'd100;
         GAS_CH4:     v = 22'd100000;
         GAS_ETHANOL: v = 22'd1000;
         GAS_H2:      v = 22'd100;
         GAS_NH3:     v = 22'd100;
         GAS_NO2:     v = 22'd10;
         default:     v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [CONC_W-1:0] curve_top(input logic [GAS_W-1:0] gas);
      logic [CONC_W-1:0] v;
      unique case (gas)
         GAS_CO:      v = 22'd100000;
         GAS_CH4:     v = 22'd2500000;
         GAS_ETHANOL: v = 22'd50000;
         GAS_H2:      v = 22'd100000;
         GAS_NH3:     v = 22'd50000;
         GAS_NO2:     v = 22'd1000;
         default:     v = '0;
      endcase
      return v;
   endfunction

   function automatic logic curve_rising(input logic [GAS_W-1:0] gas);
      return (gas == GAS_NO2);
   endfunction

endpackage
`default_nettype wire

### src/gsc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsc_div
// Bit-serial restoring divider. Starts from a partial remainder that is
// already below the divisor and shifts in the low dividend bits one per
// cycle, giving one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gsc_div
   import gsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_cmd_type       cmd,
   output logic              done,
   output logic [QUO_W-1:0]  quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  rem_ff;
   logic [QUO_W-1:0]  low_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [DIV_W-1:0]  divisor_ff;

   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    trial_sub;
   logic              fits;
   logic [DIV_W-1:0]  rem_in;

   assign trial     = {rem_ff, low_ff[QUO_W-1]};
   assign trial_sub = trial - {1'b0, divisor_ff};
   assign fits      = (trial >= {1'b0, divisor_ff});
   assign rem_in    = fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.steps;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff     <= cmd.rem_init;
         low_ff     <= cmd.low;
         quo_ff     <= '0;
         divisor_ff <= cmd.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[QUO_W-2:0], 1'b0};
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

### src/gsc_warm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsc_warm
// Millisecond counter, warm-up window tracking, baseline store and the
// warm-up minutes register.
// ----------------------------------------------------------------------------
module gsc_warm
   import gsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [MIN_W-1:0]  csr_data,
   input  logic [ADC_W-1:0]  sample,
   input  warm_cmd_type      cmd,
   output warm_stat_type     stat
);

   logic [MIN_W-1:0] minutes_ff;
   logic [MS_W-1:0]  ms_count_ff;
   logic [MS_W-1:0]  stamp_ff;
   logic             started_ff;
   logic [WIN_W-1:0] window_ff;
   logic [ADC_W-1:0] baseline_ff;

   logic [WIN_W-1:0] window_in;
   logic [MS_W-1:0]  elapsed;
   logic             warming;
   logic             capture;

   assign window_in = WIN_W'(minutes_ff) * WIN_W'(MS_PER_MINUTE);
   assign elapsed   = ms_count_ff - stamp_ff;
   assign warming   = (elapsed < MS_W'(window_ff));
   assign capture   = started_ff && !warming;

   always_ff @(posedge clock) begin
      if (reset) begin
         minutes_ff  <= MINUTES_RESET;
         ms_count_ff <= '0;
         stamp_ff    <= '0;
         started_ff  <= 1'b0;
         window_ff   <= '0;
         baseline_ff <= '0;
      end else begin
         if (csr_write) begin
            minutes_ff <= csr_data;
         end
         if (cmd.tick) begin
            ms_count_ff <= ms_count_ff + 1'b1;
         end
         if (cmd.poll) begin
            if (!started_ff) begin
               started_ff <= 1'b1;
               stamp_ff   <= ms_count_ff;
               window_ff  <= window_in;
            end else if (capture) begin
               baseline_ff <= sample;
            end
         end
      end
   end

   assign stat.capture  = capture;
   assign stat.baseline = baseline_ff;

endmodule
`default_nettype wire

### src/gas_sensor_concentration_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gas_sensor_concentration_top
// Metal-oxide gas sensor ppm conversion: tick counting, warm-up and baseline
// capture, Q16 baseline drop ratio and per-gas linear curve with clamping.
// ----------------------------------------------------------------------------
// One beat at a time. A tick, warm-up poll or bad gas code goes through the
// execute and emit states. A measurement makes up to two passes through the
// shared bit-serial divider: 16 quotient bits for the ratio and 22 for the
// concentration (the ratio pass is skipped when the ratio saturates or the
// baseline is zero, the concentration pass when the gas is not present or
// the concentration hits its top). A finished result waits in the output
// register while the next beat is taken. Kind 3 is taken and dropped.
// ----------------------------------------------------------------------------
module gas_sensor_concentration_top
   import gsc_pkg::*;
#(
   parameter int ADC_BITS = 12
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic [ADC_W-1:0]           req_adc_sample,
   input  logic [GAS_W-1:0]           req_gas,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STAT_W-1:0]          rsp_status,
   output logic [CONC_W-1:0]          rsp_concentration,
   output logic                       rsp_present,
   output logic signed [RATIO_W-1:0]  rsp_ratio,
   input  logic                       csr_wr_en,
   input  logic [MIN_W-1:0]           csr_wr_data
);

   localparam int SAMPLE_BITS = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
   localparam logic [ADC_W-1:0] SAMPLE_MASK = ADC_W'((1 << SAMPLE_BITS) - 1);

   state_type state_ff, state_in;

   logic [KIND_W-1:0]          kind_ff;
   logic [ADC_W-1:0]           sample_ff;
   logic [GAS_W-1:0]           gas_ff;
   logic                       neg_ff;
   logic signed [RATIO_W-1:0]  ratio_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       hit_ff;
   logic [BASE_W-1:0]          base_ff;
   logic [NUM_W-1:0]           num_ff;
   logic [STAT_W-1:0]          stat_ff;
   logic [CONC_W-1:0]          conc_ff;
   logic                       present_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]          rsp_status_ff;
   logic [CONC_W-1:0]          rsp_conc_ff;
   logic                       rsp_present_ff;
   logic signed [RATIO_W-1:0]  rsp_ratio_ff;

   warm_cmd_type  warm_cmd;
   warm_stat_type warm_stat;
   div_cmd_type   div_cmd;
   logic          div_done;
   logic [QUO_W-1:0] div_quo;

   logic accept, ld_exec, ld_rdiv, ld_prod, ld_base, ld_num, ld_chk, ld_cdiv, ld_rsp;
   logic out_free;

   // ratio front end
   logic                       bad_gas;
   logic signed [ADC_W:0]      drop;
   logic signed [ADC_W:0]      drop_abs;
   logic [ADC_W-1:0]           mag;
   logic                       neg;
   logic                       base_zero;
   logic                       ratio_direct;
   logic signed [RATIO_W-1:0]  direct_ratio;
   logic [STAT_W-1:0]          exec_stat_in;
   logic signed [RATIO_W-1:0]  exec_ratio_in;
   logic signed [RATIO_W-1:0]  q_mag;
   logic signed [RATIO_W-1:0]  rdiv_ratio_in;

   // curve path
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [DIFF_W-1:0]   prod_x, thr_x, off_x, diff_thr, diff_off;
   logic                       rising;
   logic                       hit_in;
   logic [BASE_W-1:0]          base_in;
   logic [NUM_W-1:0]           num_in;
   logic [DIV_W-1:0]           num_high;
   logic                       conc_sat;
   logic [CONC_W-1:0]          chk_conc_in;
   logic [CONC_W-1:0]          clamp_in;
   logic [CONC_W-1:0]          floor_v, top_v;

   gsc_warm u_warm (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_wr_en),
      .csr_data  (csr_wr_data),
      .sample    (sample_ff),
      .cmd       (warm_cmd),
      .stat      (warm_stat)
   );

   gsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ratio
   assign bad_gas      = (gas_ff >= NUM_GASES);
   assign drop         = $signed({1'b0, warm_stat.baseline}) - $signed({1'b0, sample_ff});
   assign neg          = drop[ADC_W];
   assign drop_abs     = neg ? -drop : drop;
   assign mag          = drop_abs[ADC_W-1:0];
   assign base_zero    = (warm_stat.baseline == '0);
   assign ratio_direct = base_zero || (mag >= warm_stat.baseline);
   assign direct_ratio = base_zero ? '0 : (neg ? -RATIO_ONE : RATIO_ONE);
   assign exec_ratio_in = (kind_ff == KIND_MEAS && !bad_gas) ? direct_ratio : '0;
   assign q_mag         = $signed(RATIO_W'(div_quo[Q16_W-1:0]));
   assign rdiv_ratio_in = neg_ff ? -q_mag : q_mag;

   always_comb begin
      priority if (kind_ff == KIND_TICK) begin
         exec_stat_in = STAT_TICK;
      end else if (kind_ff == KIND_POLL) begin
         exec_stat_in = warm_stat.capture ? STAT_BASELINE : STAT_WARMING;
      end else if (bad_gas) begin
         exec_stat_in = STAT_BAD_GAS;
      end else begin
         exec_stat_in = STAT_MEASURED;
      end
   end

   // curve
   assign prod_in  = PROD_W'(ratio_ff) * PROD_W'(Q16_SCALE);
   assign rising   = curve_rising(gas_ff);
   assign prod_x   = DIFF_W'(prod_ff);
   assign thr_x    = $signed(DIFF_W'(curve_thr(gas_ff)));
   assign off_x    = $signed(DIFF_W'(curve_off(gas_ff)));
   assign diff_thr = rising ? (prod_x - thr_x) : (thr_x - prod_x);
   assign diff_off = prod_x - off_x;
   assign hit_in   = !diff_thr[DIFF_W-1];
   assign base_in  = rising ? diff_off[BASE_W-1:0] : diff_thr[BASE_W-1:0];
   assign num_in   = NUM_W'(base_ff) * NUM_W'(CONC_SCALE);
   assign num_high = DIV_W'(num_ff[NUM_W-1:QUO_W]);
   assign conc_sat = (num_high >= curve_div(gas_ff));
   assign floor_v  = curve_floor(gas_ff);
   assign top_v    = curve_top(gas_ff);
   assign chk_conc_in = (hit_ff && conc_sat) ? top_v : '0;

   always_comb begin
      priority if (div_quo < floor_v) begin
         clamp_in = '0;
      end else if (div_quo > top_v) begin
         clamp_in = top_v;
      end else begin
         clamp_in = div_quo;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_kind != KIND_IGNORE) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            priority if (kind_ff != KIND_MEAS || bad_gas) begin
               state_in = ST_EMIT;
            end else if (ratio_direct) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_RDIV;
            end
         end
         ST_RDIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_NUM;
         ST_NUM:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_CHK;
         ST_CHK: begin
            state_in = (hit_ff && !conc_sat) ? ST_CDIV : ST_EMIT;
         end
         ST_CDIV: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      accept   = 1'b0;
      ld_exec  = 1'b0;
      ld_rdiv  = 1'b0;
      ld_prod  = 1'b0;
      ld_base  = 1'b0;
      ld_num   = 1'b0;
      ld_chk   = 1'b0;
      ld_cdiv  = 1'b0;
      ld_rsp   = 1'b0;
      warm_cmd = '0;
      div_cmd  = '0;
      unique case (state_ff)
         ST_IDLE: accept = req_valid;
         ST_EXEC: begin
            ld_exec       = 1'b1;
            warm_cmd.tick = (kind_ff == KIND_TICK);
            warm_cmd.poll = (kind_ff == KIND_POLL);
            if (kind_ff == KIND_MEAS && !bad_gas && !ratio_direct) begin
               div_cmd.start    = 1'b1;
               div_cmd.rem_init = DIV_W'(mag);
               div_cmd.low      = '0;
               div_cmd.steps    = RDIV_STEPS;
               div_cmd.divisor  = DIV_W'(warm_stat.baseline);
            end
         end
         ST_RDIV:  ld_rdiv = div_done;
         ST_MUL:   ld_prod = 1'b1;
         ST_NUM:   ld_base = 1'b1;
         ST_SCALE: ld_num  = 1'b1;
         ST_CHK: begin
            ld_chk = 1'b1;
            if (hit_ff && !conc_sat) begin
               div_cmd.start    = 1'b1;
               div_cmd.rem_init = num_high;
               div_cmd.low      = num_ff[QUO_W-1:0];
               div_cmd.steps    = CDIV_STEPS;
               div_cmd.divisor  = curve_div(gas_ff);
            end
         end
         ST_CDIV: ld_cdiv = div_done;
         ST_EMIT: ld_rsp  = out_free;
         default: ;
      endcase
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid_in = ld_rsp ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind;
         sample_ff <= req_adc_sample & SAMPLE_MASK;
         gas_ff    <= req_gas;
      end
      if (ld_exec) begin
         stat_ff    <= exec_stat_in;
         ratio_ff   <= exec_ratio_in;
         conc_ff    <= '0;
         present_ff <= 1'b0;
         neg_ff     <= neg;
      end
      if (ld_rdiv) begin
         ratio_ff <= rdiv_ratio_in;
      end
      if (ld_prod) begin
         prod_ff <= prod_in;
      end
      if (ld_base) begin
         hit_ff  <= hit_in;
         base_ff <= base_in;
      end
      if (ld_num) begin
         num_ff <= num_in;
      end
      if (ld_chk) begin
         present_ff <= hit_ff;
         conc_ff    <= chk_conc_in;
      end
      if (ld_cdiv) begin
         conc_ff <= clamp_in;
      end
      if (ld_rsp) begin
         rsp_status_ff  <= stat_ff;
         rsp_conc_ff    <= conc_ff;
         rsp_present_ff <= present_ff;
         rsp_ratio_ff   <= ratio_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_concentration = rsp_conc_ff;
   assign rsp_present       = rsp_present_ff;
   assign rsp_ratio         = rsp_ratio_ff;

endmodule
`default_nettype wire

### src/gsc_port_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsc_port_check
// Port-level checks on the result channel of the gas sensor concentration
// block, bound to the top level.
// ----------------------------------------------------------------------------
module gsc_port_check
   import gsc_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [STAT_W-1:0]          rsp_status,
   input logic [CONC_W-1:0]          rsp_concentration,
   input logic                       rsp_present,
   input logic signed [RATIO_W-1:0]  rsp_ratio
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_status) && $stable(rsp_concentration)
                                 && $stable(rsp_present) && $stable(rsp_ratio))
      else $error("result payload changed while stalled");

   a_present_measured: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_present |-> rsp_status == STAT_MEASURED)
      else $error("presence flag on a non-measurement beat");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_MEASURED |->
         rsp_concentration == '0 && !rsp_present && rsp_ratio == '0)
      else $error("non-measurement beat carries measurement data");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ratio <= RATIO_ONE && rsp_ratio >= -RATIO_ONE
                    && rsp_concentration <= CONC_MAX)
      else $error("ratio or concentration out of range");

endmodule

bind gas_sensor_concentration_top gsc_port_check u_port_check (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_concentration (rsp_concentration),
   .rsp_present       (rsp_present),
   .rsp_ratio         (rsp_ratio)
);
`default_nettype wire
